### sv/rcg_pkg.sv
`default_nettype none

package rcg_pkg;

    // Default parameter values
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int PALETTE_SIZE     = 7;

    // Register widths
    localparam int EDGE_BITS    = 16;
    localparam int SPACING_BITS = 10;
    localparam int TRIG_BITS    = 16;
    localparam int SEED_BITS    = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = 32;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUBE_EDGE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_SPACING = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_COSINE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_SINE     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_SEED   = 3'd4;

    // Register reset values
    localparam logic [EDGE_BITS-1:0]    EDGE_RST    = 16'd7680;
    localparam logic [SPACING_BITS-1:0] SPACING_RST = 10'd307;
    localparam logic [TRIG_BITS-1:0]    COSINE_RST  = 16'd16384;
    localparam logic [TRIG_BITS-1:0]    SINE_RST    = 16'd0;
    localparam logic [SEED_BITS-1:0]    SEED_RST    = 32'd0;

    // Datapath widths
    localparam int GQ_BITS    = EDGE_BITS + SPACING_BITS;
    localparam int DX_BITS    = GQ_BITS + 1;
    localparam int PROD_BITS  = DX_BITS + TRIG_BITS;
    localparam int ROT_BITS   = PROD_BITS + 1;
    localparam int HALF_SHIFT = 22;
    localparam int HALF_BITS  = EDGE_BITS + HALF_SHIFT;
    localparam int FRAC_SHIFT = 16;
    localparam int HASH_BITS  = 32;
    localparam int KEY_BITS   = 3;

    // Cell hash multipliers
    localparam logic [HASH_BITS-1:0] HASH_MUL_X = 32'd73856093;
    localparam logic [HASH_BITS-1:0] HASH_MUL_Y = 32'd19349663;

    // Palette level codes
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_HALF = 2'd1;
    localparam logic [1:0] LVL_FULL = 2'd2;

    typedef struct packed {
        logic [1:0] red;
        logic [1:0] green;
        logic [1:0] blue;
    } pal_entry_t;

    // Red, green, blue, yellow, cyan, magenta, orange
    function automatic pal_entry_t palette_lookup(input logic [KEY_BITS-1:0] key);
        pal_entry_t e;
        case (key)
            3'd0:    e = '{LVL_FULL, LVL_NONE, LVL_NONE};
            3'd1:    e = '{LVL_NONE, LVL_FULL, LVL_NONE};
            3'd2:    e = '{LVL_NONE, LVL_NONE, LVL_FULL};
            3'd3:    e = '{LVL_FULL, LVL_FULL, LVL_NONE};
            3'd4:    e = '{LVL_NONE, LVL_FULL, LVL_FULL};
            3'd5:    e = '{LVL_FULL, LVL_NONE, LVL_FULL};
            3'd6:    e = '{LVL_FULL, LVL_HALF, LVL_NONE};
            default: e = '{LVL_NONE, LVL_NONE, LVL_NONE};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

### sv/rotated_cube_grid_pixel_render_top.sv
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   coord_x, coord_y, in_red..in_alpha
// out       output     out_valid/out_stall out_red..out_alpha, inside_square
// cfg       input      cfg_we              cfg_index, cfg_data
//
// One pixel per clock while the output is not stalled; the divider,
// which resolves one quotient bit per stage, is followed by five stages
// of offset, rotation, compare and output.
// Reset clears all valid bits and loads the register defaults.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module rotated_cube_grid_pixel_render_top #(
    parameter int CHANNEL_BITS = rcg_pkg::CHANNEL_BITS_DEF,
    parameter int COORD_BITS   = rcg_pkg::COORD_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [COORD_BITS-1:0]     coord_x,
    input  wire logic signed [COORD_BITS-1:0]     coord_y,
    input  wire logic [CHANNEL_BITS-1:0]          in_red,
    input  wire logic [CHANNEL_BITS-1:0]          in_green,
    input  wire logic [CHANNEL_BITS-1:0]          in_blue,
    input  wire logic [CHANNEL_BITS-1:0]          in_alpha,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [CHANNEL_BITS-1:0]               out_red,
    output logic [CHANNEL_BITS-1:0]               out_green,
    output logic [CHANNEL_BITS-1:0]               out_blue,
    output logic [CHANNEL_BITS-1:0]               out_alpha,
    output logic                                  inside_square,
    input  wire logic                             cfg_we,
    input  wire logic [rcg_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [rcg_pkg::CFG_DAT_BITS-1:0] cfg_data
);

    localparam int NB  = COORD_BITS + rcg_pkg::FRAC_SHIFT;
    localparam int QW  = NB + 1;
    localparam int TOT = NB + 5;
    localparam int S4  = NB + 3;

    localparam logic [CHANNEL_BITS-1:0] FULL = {CHANNEL_BITS{1'b1}};
    localparam logic [CHANNEL_BITS-1:0] HALF = CHANNEL_BITS'(1) << (CHANNEL_BITS - 1);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] alpha;
    } pixel_t;

    // Configuration registers
    logic [rcg_pkg::EDGE_BITS-1:0]           cube_edge_reg;
    logic [rcg_pkg::SPACING_BITS-1:0]        grid_spacing_reg;
    logic signed [rcg_pkg::TRIG_BITS-1:0]    rot_cosine_reg;
    logic signed [rcg_pkg::TRIG_BITS-1:0]    rot_sine_reg;
    logic [rcg_pkg::SEED_BITS-1:0]           color_seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_edge_reg    <= rcg_pkg::EDGE_RST;
            grid_spacing_reg <= rcg_pkg::SPACING_RST;
            rot_cosine_reg   <= rcg_pkg::COSINE_RST;
            rot_sine_reg     <= rcg_pkg::SINE_RST;
            color_seed_reg   <= rcg_pkg::SEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcg_pkg::CFG_CUBE_EDGE:
                    cube_edge_reg <= cfg_data[rcg_pkg::EDGE_BITS-1:0];
                rcg_pkg::CFG_GRID_SPACING:
                    grid_spacing_reg <= cfg_data[rcg_pkg::SPACING_BITS-1:0];
                rcg_pkg::CFG_ROT_COSINE:
                    rot_cosine_reg <= cfg_data[rcg_pkg::TRIG_BITS-1:0];
                rcg_pkg::CFG_ROT_SINE:
                    rot_sine_reg <= cfg_data[rcg_pkg::TRIG_BITS-1:0];
                rcg_pkg::CFG_COLOR_SEED:
                    color_seed_reg <= cfg_data[rcg_pkg::SEED_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // Grid pitch in 2^-16 pixel units
    logic [rcg_pkg::GQ_BITS-1:0]   gq;
    logic [rcg_pkg::HALF_BITS-1:0] half_edge;
    assign gq        = rcg_pkg::GQ_BITS'(cube_edge_reg) * rcg_pkg::GQ_BITS'(grid_spacing_reg);
    assign half_edge = {cube_edge_reg, {rcg_pkg::HALF_SHIFT{1'b0}}};

    // Global advance: hold everything while the result waits
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Coordinate magnitudes scaled by 2^16 for the divider
    logic [COORD_BITS-1:0] mag_x, mag_y;
    logic [NB-1:0]         num_x, num_y;
    assign mag_x = coord_x[COORD_BITS-1] ? COORD_BITS'(~coord_x + 1'b1) : coord_x;
    assign mag_y = coord_y[COORD_BITS-1] ? COORD_BITS'(~coord_y + 1'b1) : coord_y;
    assign num_x = {mag_x, {rcg_pkg::FRAC_SHIFT{1'b0}}};
    assign num_y = {mag_y, {rcg_pkg::FRAC_SHIFT{1'b0}}};

    logic [NB-1:0]               qx, qy;
    logic [rcg_pkg::GQ_BITS-1:0] rx_rem, ry_rem;
    logic                        nx, ny;

    rcg_div #(
        .NUM_BITS (NB),
        .DEN_BITS (rcg_pkg::GQ_BITS)
    ) u_div_x (
        .clk     (clk),
        .en      (adv),
        .num     (num_x),
        .neg     (coord_x[COORD_BITS-1]),
        .den     (gq),
        .quo     (qx),
        .rem     (rx_rem),
        .neg_out (nx)
    );

    rcg_div #(
        .NUM_BITS (NB),
        .DEN_BITS (rcg_pkg::GQ_BITS)
    ) u_div_y (
        .clk     (clk),
        .en      (adv),
        .num     (num_y),
        .neg     (coord_y[COORD_BITS-1]),
        .den     (gq),
        .quo     (qy),
        .rem     (ry_rem),
        .neg_out (ny)
    );

    // Valid bits and pixel payload travel alongside
    logic   vld_reg  [TOT];
    logic   vld_next [TOT];
    pixel_t pix_reg  [TOT-1];
    pixel_t pix_next [TOT-1];

    always_comb
    begin
        vld_next[0] = in_valid;
        pix_next[0] = '{in_red, in_green, in_blue, in_alpha};
        for (int i = 1; i < TOT; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
        for (int i = 1; i < TOT - 1; i++)
        begin
            pix_next[i] = pix_reg[i-1];
        end
    end

    // Floor quotient and offset from cell centre
    logic signed [QW-1:0]               cqx_reg, cqx_next, cqy_reg, cqy_next;
    logic signed [rcg_pkg::DX_BITS-1:0] dx_reg, dx_next, dy_reg, dy_next;

    always_comb
    begin
        logic                        nzx, nzy;
        logic [rcg_pkg::GQ_BITS-1:0] rfx, rfy;
        nzx = (rx_rem != '0);
        nzy = (ry_rem != '0);
        if (nx)
        begin
            cqx_next = nzx ? ~QW'(qx) : QW'(-QW'(qx));
            rfx      = nzx ? rcg_pkg::GQ_BITS'(gq - rx_rem) : '0;
        end
        else
        begin
            cqx_next = QW'(qx);
            rfx      = rx_rem;
        end
        if (ny)
        begin
            cqy_next = nzy ? ~QW'(qy) : QW'(-QW'(qy));
            rfy      = nzy ? rcg_pkg::GQ_BITS'(gq - ry_rem) : '0;
        end
        else
        begin
            cqy_next = QW'(qy);
            rfy      = ry_rem;
        end
        dx_next = rcg_pkg::DX_BITS'({rfx, 1'b0} - {1'b0, gq});
        dy_next = rcg_pkg::DX_BITS'({rfy, 1'b0} - {1'b0, gq});
    end

    // Rotation products, sums and the square test
    logic signed [rcg_pkg::PROD_BITS-1:0] pxc_reg, pxc_next, pys_reg, pys_next;
    logic signed [rcg_pkg::PROD_BITS-1:0] pxs_reg, pxs_next, pyc_reg, pyc_next;
    logic signed [rcg_pkg::ROT_BITS-1:0]  rotx_reg, rotx_next, roty_reg, roty_next;
    logic                                 in_sq_reg, in_sq_next;

    always_comb
    begin
        logic [rcg_pkg::ROT_BITS-1:0] ax, ay;
        pxc_next  = dx_reg * rot_cosine_reg;
        pys_next  = dy_reg * rot_sine_reg;
        pxs_next  = dx_reg * rot_sine_reg;
        pyc_next  = dy_reg * rot_cosine_reg;
        rotx_next = rcg_pkg::ROT_BITS'(pxc_reg) - rcg_pkg::ROT_BITS'(pys_reg);
        roty_next = rcg_pkg::ROT_BITS'(pxs_reg) + rcg_pkg::ROT_BITS'(pyc_reg);
        ax = rotx_reg[rcg_pkg::ROT_BITS-1] ? rcg_pkg::ROT_BITS'(-rotx_reg) : rotx_reg;
        ay = roty_reg[rcg_pkg::ROT_BITS-1] ? rcg_pkg::ROT_BITS'(-roty_reg) : roty_reg;
        in_sq_next = (gq != '0)
                  && (ax < rcg_pkg::ROT_BITS'(half_edge))
                  && (ay < rcg_pkg::ROT_BITS'(half_edge));
    end

    // Cell indices enter the hash in their low 32 bits
    logic signed [QW+rcg_pkg::HASH_BITS-1:0] cxw, cyw;
    logic [rcg_pkg::KEY_BITS-1:0]            key;
    assign cxw = cqx_reg;
    assign cyw = cqy_reg;

    rcg_hash u_hash (
        .clk    (clk),
        .en     (adv),
        .seed   (color_seed_reg),
        .cell_x (cxw[rcg_pkg::HASH_BITS-1:0]),
        .cell_y (cyw[rcg_pkg::HASH_BITS-1:0]),
        .key    (key)
    );

    // Output select
    logic [CHANNEL_BITS-1:0] red_reg, red_next, green_reg, green_next;
    logic [CHANNEL_BITS-1:0] blue_reg, blue_next, alpha_reg, alpha_next;
    logic                    inside_reg, inside_next;

    function automatic logic [CHANNEL_BITS-1:0] level(input logic [1:0] code);
        logic [CHANNEL_BITS-1:0] v;
        case (code)
            rcg_pkg::LVL_FULL: v = FULL;
            rcg_pkg::LVL_HALF: v = HALF;
            default:           v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        rcg_pkg::pal_entry_t pe;
        pixel_t              p;
        logic                clear;
        p     = pix_reg[S4];
        pe    = rcg_pkg::palette_lookup(key);
        clear = (p.alpha == '0);
        inside_next = in_sq_reg;
        if (in_sq_reg)
        begin
            red_next   = level(pe.red);
            green_next = level(pe.green);
            blue_next  = level(pe.blue);
            alpha_next = clear ? FULL : p.alpha;
        end
        else if (clear)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
            alpha_next = FULL;
        end
        else
        begin
            red_next   = p.red;
            green_next = p.green;
            blue_next  = p.blue;
            alpha_next = p.alpha;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix_reg    <= pix_next;
            cqx_reg    <= cqx_next;
            cqy_reg    <= cqy_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            pxc_reg    <= pxc_next;
            pys_reg    <= pys_next;
            pxs_reg    <= pxs_next;
            pyc_reg    <= pyc_next;
            rotx_reg   <= rotx_next;
            roty_reg   <= roty_next;
            in_sq_reg  <= in_sq_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            alpha_reg  <= alpha_next;
            inside_reg <= inside_next;
        end
    end

    assign out_valid     = vld_reg[TOT-1];
    assign out_red       = red_reg;
    assign out_green     = green_reg;
    assign out_blue      = blue_reg;
    assign out_alpha     = alpha_reg;
    assign inside_square = inside_reg;

`ifndef SYNTHESIS
    // A delivered pixel is never transparent
    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_alpha != '0))
        else $error("transparent pixel delivered");

    // Palette channels take only the three palette levels
    a_palette_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && inside_square) |->
            ((out_red == '0 || out_red == FULL)
             && (out_green == '0 || out_green == FULL || out_green == HALF)
             && (out_blue == '0 || out_blue == FULL)))
        else $error("palette colour out of set");

    // A held result keeps the first stage's valid bit in place
    a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (vld_reg[0] == $past(vld_reg[0])))
        else $error("pipeline moved under stall");
`endif

endmodule

`default_nettype wire

### sv/rcg_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage
module rcg_div #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 26
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic                neg,
    input  wire logic [DEN_BITS-1:0] den,
    output logic      [NUM_BITS-1:0] quo,
    output logic      [DEN_BITS-1:0] rem,
    output logic                     neg_out
);

    logic [DEN_BITS-1:0] rem_reg  [NUM_BITS];
    logic [DEN_BITS-1:0] rem_next [NUM_BITS];
    logic [NUM_BITS-1:0] quo_reg  [NUM_BITS];
    logic [NUM_BITS-1:0] quo_next [NUM_BITS];
    logic [NUM_BITS-1:0] num_reg  [NUM_BITS];
    logic [NUM_BITS-1:0] num_next [NUM_BITS];
    logic                neg_reg  [NUM_BITS];
    logic                neg_next [NUM_BITS];

    // One trial subtraction per stage
    always_comb
    begin
        logic [DEN_BITS-1:0] r_in;
        logic [NUM_BITS-1:0] q_in;
        logic [NUM_BITS-1:0] n_in;
        logic                s_in;
        logic [DEN_BITS:0]   trial;
        for (int i = 0; i < NUM_BITS; i++)
        begin
            if (i == 0)
            begin
                r_in = '0;
                q_in = '0;
                n_in = num;
                s_in = neg;
            end
            else
            begin
                r_in = rem_reg[i-1];
                q_in = quo_reg[i-1];
                n_in = num_reg[i-1];
                s_in = neg_reg[i-1];
            end
            trial = {r_in, n_in[NUM_BITS-1]};
            if (trial >= {1'b0, den})
            begin
                rem_next[i] = DEN_BITS'(trial - {1'b0, den});
                quo_next[i] = {q_in[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[DEN_BITS-1:0];
                quo_next[i] = {q_in[NUM_BITS-2:0], 1'b0};
            end
            num_next[i] = {n_in[NUM_BITS-2:0], 1'b0};
            neg_next[i] = s_in;
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            num_reg <= num_next;
            neg_reg <= neg_next;
        end
    end

    assign quo     = quo_reg[NUM_BITS-1];
    assign rem     = rem_reg[NUM_BITS-1];
    assign neg_out = neg_reg[NUM_BITS-1];

endmodule

`default_nettype wire

### sv/rcg_hash.sv
`default_nettype none

// Cell colour hash: products, sum with seed, then modulo seven
module rcg_hash (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [rcg_pkg::SEED_BITS-1:0]     seed,
    input  wire logic [rcg_pkg::HASH_BITS-1:0]     cell_x,
    input  wire logic [rcg_pkg::HASH_BITS-1:0]     cell_y,
    output logic      [rcg_pkg::KEY_BITS-1:0]      key
);

    logic [rcg_pkg::HASH_BITS-1:0] mx_reg, mx_next;
    logic [rcg_pkg::HASH_BITS-1:0] my_reg, my_next;
    logic [rcg_pkg::HASH_BITS-1:0] h_reg, h_next;
    logic [rcg_pkg::KEY_BITS-1:0]  key_reg, key_next;

    // Wrapping products and sum
    always_comb
    begin
        mx_next = rcg_pkg::HASH_BITS'(cell_x * rcg_pkg::HASH_MUL_X);
        my_next = rcg_pkg::HASH_BITS'(cell_y * rcg_pkg::HASH_MUL_Y);
        h_next  = rcg_pkg::HASH_BITS'(seed + mx_reg + my_reg);
    end

    // Fold octal digits, since eight is one modulo seven
    always_comb
    begin
        logic [6:0]                    s1;
        logic [3:0]                    s2;
        logic [3:0]                    s3;
        logic [rcg_pkg::HASH_BITS+0:0] hp;
        hp = {1'b0, h_reg};
        s1 = '0;
        for (int i = 0; i < 11; i++)
        begin
            s1 = s1 + 7'(hp[3*i +: 3]);
        end
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]) + 4'(s1[6]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        if (s3 >= 4'd7)
        begin
            s3 = s3 - 4'd7;
        end
        key_next = s3[2:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            h_reg   <= h_next;
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

`default_nettype wire

### test/rotated_cube_grid_pixel_render_top_test.sv
`timescale 1ns / 100ps

module rotated_cube_grid_pixel_render_top_test;

    localparam int           LATENCY     = 16 + 21;
    localparam int           CYCLE_LIMIT = 400000;
    localparam logic [15:0]  FULL_LVL    = 16'hFFFF;
    localparam logic [15:0]  HALF_LVL    = 16'h8000;
    localparam int           PHASE_ITEMS = 160;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        r;
        logic [15:0]        g;
        logic [15:0]        b;
        logic [15:0]        a;
    } pixel_in_t;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
        logic        ins;
    } pixel_out_t;

    typedef struct packed {
        pixel_in_t  px;
        logic       known;
        pixel_out_t res;
    } vector_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [15:0] in_red;
    logic [15:0] in_green;
    logic [15:0] in_blue;
    logic [15:0] in_alpha;
    logic out_valid;
    logic out_stall;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic inside_square;
    logic cfg_we;
    logic [rcg_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [rcg_pkg::CFG_DAT_BITS-1:0] cfg_data;

    // Shadow copy of the block's registers
    logic [15:0]        edge_q;
    logic [9:0]         spacing_q;
    logic signed [15:0] cos_q;
    logic signed [15:0] sin_q;
    logic [31:0]        seed_q;

    pixel_out_t pending_pixels[$];
    int mismatches;
    int cycles;
    int send_idle;
    int recv_idle;
    bit hold_req;
    int hold_left;

    rotated_cube_grid_pixel_render_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .coord_x(coord_x), .coord_y(coord_y),
        .in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha), .inside_square(inside_square),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // Work out the rendered pixel from the shadow registers
    function automatic pixel_out_t render_pixel(pixel_in_t p);
        longint px, py, gq, cx, cy, dx, dy, rx, ry, half;
        logic [31:0] h;
        int k;
        pixel_out_t o;
        px = p.x;
        py = p.y;
        gq = longint'(edge_q) * longint'(spacing_q);
        o.ins = 1'b0;
        cx = 0;
        cy = 0;
        if (gq > 0)
        begin
            cx = floor_div(px * 65536, gq);
            cy = floor_div(py * 65536, gq);
            dx = px * 131072 - (2 * cx + 1) * gq;
            dy = py * 131072 - (2 * cy + 1) * gq;
            rx = dx * longint'(cos_q) - dy * longint'(sin_q);
            ry = dx * longint'(sin_q) + dy * longint'(cos_q);
            if (rx < 0) rx = -rx;
            if (ry < 0) ry = -ry;
            half = longint'(edge_q) * 4194304;
            o.ins = (rx < half) && (ry < half);
        end
        if (o.ins)
        begin
            h = seed_q + cx[31:0] * rcg_pkg::HASH_MUL_X + cy[31:0] * rcg_pkg::HASH_MUL_Y;
            k = h % rcg_pkg::PALETTE_SIZE;
            case (k)
                0: {o.r, o.g, o.b} = {FULL_LVL, 16'd0, 16'd0};
                1: {o.r, o.g, o.b} = {16'd0, FULL_LVL, 16'd0};
                2: {o.r, o.g, o.b} = {16'd0, 16'd0, FULL_LVL};
                3: {o.r, o.g, o.b} = {FULL_LVL, FULL_LVL, 16'd0};
                4: {o.r, o.g, o.b} = {16'd0, FULL_LVL, FULL_LVL};
                5: {o.r, o.g, o.b} = {FULL_LVL, 16'd0, FULL_LVL};
                default: {o.r, o.g, o.b} = {FULL_LVL, HALF_LVL, 16'd0};
            endcase
            o.a = (p.a == 0) ? FULL_LVL : p.a;
        end
        else if (p.a == 0)
        begin
            {o.r, o.g, o.b, o.a} = {16'd0, 16'd0, 16'd0, FULL_LVL};
        end
        else
        begin
            {o.r, o.g, o.b, o.a} = {p.r, p.g, p.b, p.a};
        end
        return o;
    endfunction

    // Write one register; the caller lowers the enable after the last write
    task automatic write_reg(logic [rcg_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            rcg_pkg::CFG_CUBE_EDGE:    edge_q    = val[15:0];
            rcg_pkg::CFG_GRID_SPACING: spacing_q = val[9:0];
            rcg_pkg::CFG_ROT_COSINE:   cos_q     = val[15:0];
            rcg_pkg::CFG_ROT_SINE:     sin_q     = val[15:0];
            rcg_pkg::CFG_COLOR_SEED:   seed_q    = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] e, logic [31:0] s, logic [31:0] c,
                                  logic [31:0] sn, logic [31:0] seed);
        write_reg(rcg_pkg::CFG_CUBE_EDGE, e);
        write_reg(rcg_pkg::CFG_GRID_SPACING, s);
        write_reg(rcg_pkg::CFG_ROT_COSINE, c);
        write_reg(rcg_pkg::CFG_ROT_SINE, sn);
        write_reg(rcg_pkg::CFG_COLOR_SEED, seed);
        cfg_we <= 1'b0;
    endtask

    // Offer one request and hold it until the block takes it
    task automatic send_pixel(pixel_in_t p, pixel_out_t res);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_x  <= p.x;
        coord_y  <= p.y;
        in_red   <= p.r;
        in_green <= p.g;
        in_blue  <= p.b;
        in_alpha <= p.a;
        do
            @(posedge clk);
        while (in_stall);
        pending_pixels.push_back(res);
    endtask

    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        p.x = 16'($urandom);
        p.y = 16'($urandom);
        p.r = 16'($urandom);
        p.g = 16'($urandom);
        p.b = 16'($urandom);
        p.a = 16'($urandom);
        if ($urandom_range(1) != 0)
        begin
            p.x = 16'($urandom_range(600) - 300);
            p.y = 16'($urandom_range(600) - 300);
        end
        if ($urandom_range(4) == 0)
            p.a = 16'd0;
        return p;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Compare each taken result and drive the output stall
    always @(posedge clk)
    begin
        pixel_out_t got;
        pixel_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {out_red, out_green, out_blue, out_alpha, inside_square};
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel out: %h", got);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel differs: expected rgba %h %h %h %h in %b,",
                                  " got %h %h %h %h in %b"},
                                 want.r, want.g, want.b, want.a, want.ins,
                                 got.r, got.g, got.b, got.a, got.ins);
                end
            end
        end
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rotated_cube_grid_pixel_render_top: mismatch");
            $finish;
        end
    end

    vector_t vectors[10];

    initial
    begin
        pixel_in_t p;
        pixel_out_t none_out;
        int phase;
        logic [31:0] e, s, c, sn, seed;
        none_out = '0;
        mismatches = 0;
        cycles = 0;
        hold_req = 1'b0;
        hold_left = 0;
        send_idle = 26;
        recv_idle = 54;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        coord_x = '0;
        coord_y = '0;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        in_alpha = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        edge_q = rcg_pkg::EDGE_RST;
        spacing_q = rcg_pkg::SPACING_RST;
        cos_q = rcg_pkg::COSINE_RST;
        sin_q = rcg_pkg::SINE_RST;
        seed_q = rcg_pkg::SEED_RST;

        // Default pitch is just under 36 pixels: the first cell centre sits near (18, 18), red
        vectors[0] = '{'{16'sd18, 16'sd18, 16'd1, 16'd2, 16'd3, 16'd1234}, 1'b1,
                       '{FULL_LVL, 16'd0, 16'd0, 16'd1234, 1'b1}};
        vectors[1] = '{'{16'sd18, 16'sd18, 16'd1, 16'd2, 16'd3, 16'd0}, 1'b1,
                       '{FULL_LVL, 16'd0, 16'd0, FULL_LVL, 1'b1}};
        vectors[2] = '{'{16'sd0, 16'sd0, 16'd10, 16'd20, 16'd30, 16'd40}, 1'b1,
                       '{16'd10, 16'd20, 16'd30, 16'd40, 1'b0}};
        vectors[3] = '{'{16'sd0, 16'sd0, 16'd10, 16'd20, 16'd30, 16'd0}, 1'b1,
                       '{16'd0, 16'd0, 16'd0, FULL_LVL, 1'b0}};
        vectors[4] = '{'{-16'sd32768, -16'sd32768, FULL_LVL, FULL_LVL, FULL_LVL, FULL_LVL},
                       1'b0, none_out};
        vectors[5] = '{'{16'sd32767, 16'sd32767, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, none_out};
        vectors[6] = '{'{16'sd32767, -16'sd32768, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00},
                       1'b0, none_out};
        vectors[7] = '{'{-16'sd1, -16'sd1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 1'b0, none_out};
        vectors[8] = '{'{16'sd54, 16'sd18, 16'h1111, 16'h2222, 16'h3333, 16'h4444}, 1'b0, none_out};
        vectors[9] = '{'{-16'sd18, -16'sd18, 16'h7777, 16'h8888, 16'h9999, 16'd0}, 1'b0, none_out};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels at the reset settings
        foreach (vectors[i])
            send_pixel(vectors[i].px,
                       vectors[i].known ? vectors[i].res : render_pixel(vectors[i].px));
        wait_drained();

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: {e, s, c, sn, seed} = {32'd7680, 32'd307, 32'd16384, 32'd0, 32'd0};
                1: {e, s, c, sn, seed} = {32'd2560, 32'd256, 32'd11585, 32'd11585, 32'hFFFFFFFF};
                2: {e, s, c, sn, seed} = {32'd51200, 32'd512, -32'sd16384, 32'd0, $urandom};
                3: {e, s, c, sn, seed} = {32'd0, 32'd307, 32'($urandom), 32'($urandom), $urandom};
                4: {e, s, c, sn, seed} = {32'd7680, 32'd0, 32'd16384, 32'd0, $urandom};
                5: {e, s, c, sn, seed} = {32'hFFFF, 32'h3FF, 32'h7FFF, 32'h8000, $urandom};
                6: {e, s, c, sn, seed} = {32'd1, 32'd1, 32'd16384, -32'sd16384, $urandom};
                default:
                    {e, s, c, sn, seed} = {32'($urandom_range(51200, 2560)),
                                           32'($urandom_range(512, 256)),
                                           32'($urandom_range(32768) - 16384),
                                           32'($urandom_range(32768) - 16384), $urandom};
            endcase
            apply_settings(e, s, c, sn, seed);
            if (phase < 3)
            begin
                send_idle = 26;
                recv_idle = 54;
            end
            else if (phase < 6)
            begin
                send_idle = 54;
                recv_idle = 26;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            // Hold the output off for a long stretch so the pipe backs up
            if (phase == 2)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                p = random_pixel();
                send_pixel(p, render_pixel(p));
            end
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("rotated_cube_grid_pixel_render_top: match");
        else
            $display("rotated_cube_grid_pixel_render_top: mismatch");
        $finish;
    end

endmodule

### files.f
sv/rcg_pkg.sv
sv/rcg_div.sv
sv/rcg_hash.sv
sv/rotated_cube_grid_pixel_render_top.sv
test/rotated_cube_grid_pixel_render_top_test.sv
